/* src/sacl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Sizes, field positions and shared types of the cache tag lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W     = 40;
  localparam int BYTE_OFF_W = 2;
  localparam int WORD_OFF_W = 4;
  localparam int SET_W      = 6;
  localparam int WAY_W      = 3;
  localparam int SETS       = 1 << SET_W;
  localparam int WAYS       = 1 << WAY_W;
  localparam int OFF_LSB    = BYTE_OFF_W;
  localparam int SET_LSB    = OFF_LSB + WORD_OFF_W;
  localparam int TAG_LSB    = SET_LSB + SET_W;
  localparam int TAG_W      = ADDR_W - TAG_LSB;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef logic [TAG_W-1:0]      tag_t;
  typedef logic [SET_W-1:0]      set_t;
  typedef logic [WAY_W-1:0]      way_t;
  typedef logic [WORD_OFF_W-1:0] woff_t;

  // One way of a set: valid flag and stored tag.
  typedef struct packed {
    logic vld;
    tag_t tag;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] row_t;

  // Write-back of one set row.
  typedef struct packed {
    logic en;
    set_t addr;
    row_t row;
  } row_wr_t;

  // Outcome of comparing a request tag against one set.
  typedef struct packed {
    logic hit;
    way_t way;
  } match_t;

endpackage : sacl_pkg
`default_nettype wire

/* src/sacl_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_req_if
// Request channel: action, byte address and victim way.
// ----------------------------------------------------------------------------
interface sacl_req_if
  import sacl_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic                action;
  logic [ADDR_W-1:0]   address;
  way_t                victim_way;

  modport source (output valid, action, address, victim_way, input ready);
  modport sink   (input valid, action, address, victim_way, output ready);
endinterface : sacl_req_if
`default_nettype wire

/* src/sacl_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_rsp_if
// Result channel: hit, way, set, word offset and memory request flag.
// ----------------------------------------------------------------------------
interface sacl_rsp_if
  import sacl_pkg::*;
  ;
  logic  valid;
  logic  ready;
  logic  hit;
  way_t  way;
  set_t  set_index;
  woff_t word_offset;
  logic  memory_request;

  modport source (output valid, hit, way, set_index, word_offset, memory_request,
                  input ready);
  modport sink   (input valid, hit, way, set_index, word_offset, memory_request,
                  output ready);
endinterface : sacl_rsp_if
`default_nettype wire

/* src/set_assoc_cache_tag_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag lookup of an 8-way set-associative cache, random replacement,
// write-through, allocate on every miss.
// ----------------------------------------------------------------------------
// Timing: an accepted request is held in the lookup stage while its set row is
//   read, then moves into the result register once that register is free.
// Issue: a new transaction is taken only once the lookup stage is empty,
//   after the read-modify-write of one set row through the tag memory.
// Reset: clears the pipeline valid flags and the 64 per-set row valid flags;
//   the tag memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup
  import sacl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sacl_req_if.sink   in_req,
  sacl_rsp_if.source out_rsp
);

  // Lookup stage: holds the request while its set row comes out of memory.
  logic  lk_valid_r;
  logic  lk_action_r;
  tag_t  lk_tag_r;
  set_t  lk_set_r;
  woff_t lk_offset_r;
  way_t  lk_victim_r;

  // Result register: decouples the lookup from the output handshake.
  logic  out_valid_r;
  logic  out_hit_r;
  way_t  out_way_r;
  set_t  out_set_r;
  woff_t out_offset_r;
  logic  out_mreq_r;

  logic    in_fire;
  logic    lk_done;
  row_t    rd_row;
  row_t    new_row;
  match_t  mt;
  row_wr_t wr;

  // Take a new transaction whenever the lookup stage is empty, even while a
  // finished result still waits on the output.
  assign in_req.ready = !lk_valid_r;
  assign in_fire      = in_req.valid && in_req.ready;

  // Finish the lookup once the result register can take it.
  assign lk_done = lk_valid_r && (!out_valid_r || out_rsp.ready);

  sacl_tag_ram u_tag_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_req.address[SET_LSB +: SET_W]),
    .rd_row  (rd_row),
    .wr      (wr)
  );

  sacl_way_match u_way_match (
    .row     (rd_row),
    .tag     (lk_tag_r),
    .victim  (lk_victim_r),
    .result  (mt),
    .new_row (new_row)
  );

  // Write back the row only on a miss: the victim way takes the new tag.
  // The next read of any row is issued no earlier than the edge after this
  // write, so no forwarding is needed.
  always_comb begin
    wr.en   = lk_done && !mt.hit;
    wr.addr = lk_set_r;
    wr.row  = new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r <= 1'b0;
    end else if (in_fire) begin
      lk_valid_r <= 1'b1;
    end else if (lk_done) begin
      lk_valid_r <= 1'b0;
    end
  end

  // Split the address into word offset, set and tag on acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lk_action_r <= in_req.action;
      lk_tag_r    <= in_req.address[TAG_LSB +: TAG_W];
      lk_set_r    <= in_req.address[SET_LSB +: SET_W];
      lk_offset_r <= in_req.address[OFF_LSB +: WORD_OFF_W];
      lk_victim_r <= in_req.victim_way;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lk_done) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Memory request goes out on every miss and on every write (write-through).
  always_ff @(posedge clk) begin
    if (lk_done) begin
      out_hit_r    <= mt.hit;
      out_way_r    <= mt.way;
      out_set_r    <= lk_set_r;
      out_offset_r <= lk_offset_r;
      out_mreq_r   <= !mt.hit || (lk_action_r == ACT_WRITE);
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.hit            = out_hit_r;
  assign out_rsp.way            = out_way_r;
  assign out_rsp.set_index      = out_set_r;
  assign out_rsp.word_offset    = out_offset_r;
  assign out_rsp.memory_request = out_mreq_r;

  // A lookup stalled by the output keeps its request.
  a_lk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    lk_valid_r && !lk_done |=> lk_valid_r && $stable(lk_set_r) && $stable(lk_tag_r))
    else $error("lookup stage lost its request while stalled");

  // A completed lookup always lands in the result register.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    lk_done |=> out_valid_r)
    else $error("completed lookup did not reach the output");

  // A miss always asks memory.
  a_miss_mreq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_mreq_r)
    else $error("miss without memory request");

  // The tag memory is written only at completion of a miss.
  a_wr_miss: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> lk_valid_r && !mt.hit)
    else $error("tag write outside a miss");

endmodule : set_assoc_cache_tag_lookup
`default_nettype wire

/* src/sacl_tag_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_tag_ram
// Set-row tag store with registered read and per-row valid flags.
// ----------------------------------------------------------------------------
module sacl_tag_ram
  import sacl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    rd_en,
  input  wire set_t    rd_addr,
  output row_t         rd_row,
  input  wire row_wr_t wr
);

  row_t             mem [SETS];
  logic [SETS-1:0]  row_vld_r;
  row_t             rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  // Mark a row as written; rows never written read back as invalid ways with all-ones tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr.en) begin
      row_vld_r[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_row[w].vld = rd_vld_r & rd_q_r[w].vld;
      rd_row[w].tag = rd_vld_r ? rd_q_r[w].tag : '1;
    end
  end

endmodule : sacl_tag_ram
`default_nettype wire

/* src/sacl_way_match.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_way_match
// Parallel tag compare over one set, lowest-way priority, victim fill row.
// ----------------------------------------------------------------------------
module sacl_way_match
  import sacl_pkg::*;
(
  input  wire row_t  row,
  input  wire tag_t  tag,
  input  wire way_t  victim,
  output match_t     result,
  output row_t       new_row
);

  logic [WAYS-1:0] match;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row[w].vld && (row[w].tag == tag);
    end
  end

  // Scan from the top down so the lowest matching way wins.
  always_comb begin
    result.hit = |match;
    result.way = victim;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        result.way = way_t'(w);
      end
    end
  end

  always_comb begin
    new_row             = row;
    new_row[victim].vld = 1'b1;
    new_row[victim].tag = tag;
  end

endmodule : sacl_way_match
`default_nettype wire
